/* design/vktm_pkg.sv */
// shared types, constants and state encodings for the volume knob taper and mute block
// no dependencies
package vktm_pkg;

    localparam int unsigned LEVEL_W = 12;
    localparam int unsigned GAIN_W  = 9;
    localparam int unsigned PROD_W  = 24;
    localparam int unsigned QUOT_W  = 12;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned RECIP_W     = 25;
    localparam int unsigned RECIP_SHIFT = 36;

    localparam logic [LEVEL_W-1:0] C_LEVEL_MAX  = 12'd4095;
    localparam logic [LEVEL_W-1:0] C_TAPER_LOW  = 12'd700;
    localparam logic [LEVEL_W-1:0] C_TAPER_HIGH = 12'd4000;
    localparam logic [LEVEL_W-1:0] C_TAPER_SPAN = 12'd3300;
    localparam logic [LEVEL_W-1:0] C_GAIN_FULL  = 12'd256;
    localparam logic [10:0]        C_GAIN_ROUND = 11'd2000;

    // ceil(2^36 / divisor), exact for dividends below 2^24
    localparam logic [RECIP_W-1:0] C_RECIP_SPAN = 25'd20824084;
    localparam logic [RECIP_W-1:0] C_RECIP_HIGH = 25'd17179870;

    localparam logic [LEVEL_W-1:0] C_ENTER_RST = 12'd650;
    localparam logic [LEVEL_W-1:0] C_EXIT_RST  = 12'd850;

    localparam logic [CFG_IDX_W-1:0] CFG_AUDIO_READY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MUTE_ENTER  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MUTE_EXIT   = 2'd2;

    localparam logic [1:0] STEP_RESCALE = 2'd0;
    localparam logic [1:0] STEP_SQUARE  = 2'd1;
    localparam logic [1:0] STEP_CUBE    = 2'd2;
    localparam logic [1:0] STEP_SCALE   = 2'd3;

    typedef struct packed {
        logic                start;
        logic [PROD_W-1:0]   dividend;
        logic [LEVEL_W-1:0]  divisor;
    } t_div_req;

    typedef enum logic [2:0] {
        TP_IDLE,
        TP_MUL,
        TP_DIV,
        TP_WAIT,
        TP_DONE
    } t_taper_state;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } t_top_state;

endpackage

/* design/vktm_div.sv */
// shared divider by the taper constants 3300 and 4000: reciprocal multiply, registered quotient
// depends on vktm_pkg
module vktm_div
    import vktm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_div_req           i_req,
    output logic               o_done,
    output logic [QUOT_W-1:0]  o_quot
);

    logic [QUOT_W-1:0]          r_quot;
    logic                       r_done;

    logic [RECIP_W-1:0]         w_recip;
    logic [PROD_W+RECIP_W-1:0]  w_prod;

    assign w_recip = (i_req.divisor == C_TAPER_SPAN) ? C_RECIP_SPAN : C_RECIP_HIGH;
    assign w_prod  = {{RECIP_W{1'b0}}, i_req.dividend} * {{PROD_W{1'b0}}, w_recip};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_req.start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quot <= w_prod[RECIP_SHIFT+QUOT_W-1:RECIP_SHIFT];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

/* design/vktm_taper.sv */
// cubic taper sequencer: one registered multiplier and the shared divider, four passes
// depends on vktm_pkg and vktm_div
module vktm_taper
    import vktm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [LEVEL_W-1:0]  i_level,
    output logic                o_done,
    output logic [GAIN_W-1:0]   o_gain
);

    t_taper_state        r_state;
    t_taper_state        n_state;
    logic [1:0]          r_step;
    logic [LEVEL_W-1:0]  r_opa;
    logic [LEVEL_W-1:0]  r_opb;
    logic [10:0]         r_add;
    logic [PROD_W-1:0]   r_prod;
    logic [GAIN_W-1:0]   r_gain;

    t_div_req            w_req;
    logic                w_div_done;
    logic [QUOT_W-1:0]   w_quot;
    logic                w_low;
    logic                w_high;

    assign w_low  = (i_level <= C_TAPER_LOW);
    assign w_high = (i_level >= C_TAPER_HIGH);

    vktm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            TP_IDLE: begin
                if (i_start) begin
                    n_state = (w_low || w_high) ? TP_DONE : TP_MUL;
                end
            end
            TP_MUL:  n_state = TP_DIV;
            TP_DIV:  n_state = TP_WAIT;
            TP_WAIT: begin
                if (w_div_done) begin
                    n_state = (r_step == STEP_SCALE) ? TP_DONE : TP_MUL;
                end
            end
            TP_DONE: n_state = TP_IDLE;
            default: n_state = TP_IDLE;
        endcase
    end

    always_comb begin
        w_req.start    = (r_state == TP_DIV);
        w_req.dividend = r_prod;
        w_req.divisor  = (r_step == STEP_RESCALE) ? C_TAPER_SPAN : C_TAPER_HIGH;
        o_done         = (r_state == TP_DONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= TP_IDLE;
            r_step  <= STEP_RESCALE;
        end else begin
            r_state <= n_state;
            if (r_state == TP_IDLE) begin
                r_step <= STEP_RESCALE;
            end else if (r_state == TP_WAIT && w_div_done) begin
                r_step <= r_step + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            TP_IDLE: begin
                if (i_start) begin
                    r_opa  <= i_level - C_TAPER_LOW;
                    r_opb  <= C_TAPER_HIGH;
                    r_add  <= '0;
                    r_gain <= w_high ? C_GAIN_FULL[GAIN_W-1:0] : '0;
                end
            end
            TP_MUL: begin
                r_prod <= r_opa * r_opb + {13'd0, r_add};
            end
            TP_WAIT: begin
                if (w_div_done) begin
                    case (r_step)
                        STEP_RESCALE: begin
                            r_opa <= w_quot;
                            r_opb <= w_quot;
                        end
                        STEP_SQUARE: begin
                            // r_opb still holds the rescaled level
                            r_opa <= w_quot;
                        end
                        STEP_CUBE: begin
                            r_opa <= w_quot;
                            r_opb <= C_GAIN_FULL;
                            r_add <= C_GAIN_ROUND;
                        end
                        STEP_SCALE: begin
                            r_gain <= w_quot[GAIN_W-1:0];
                        end
                        default: begin
                            r_gain <= '0;
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase
    end

    assign o_gain = r_gain;

endmodule

/* design/volume_knob_taper_mute_unit.sv */
// volume knob taper and mute: top level with stream ports, smoother, mute hysteresis,
// output register; depends on vktm_pkg and vktm_taper
//
// one knob reading per request; a reading whose smoothed level lies strictly between
// 700 and 4000 runs four taper passes (rescale, square, cube, gain scale), each made of
// a multiply, a divide by 3300 or 4000 in the shared reciprocal unit and the quotient
// handoff. o_s_axis_tready rises as its result is loaded, so a new reading is accepted only
// once the last one is through; a level at either end of the taper skips the passes and
// goes straight to the done state. o_s_axis_tready is low while a reading is in flight
// and while a finished result waits behind a full output register, so o_m_axis
// backpressure also holds off new readings. mute follows the raw reading and is forced
// high when audio_ready is 0.
module volume_knob_taper_mute_unit
    import vktm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [15:0]           i_s_axis_tdata,   // adc_code[11:0], zero pad
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [15:0]           o_m_axis_tdata,   // gain[8:0], muted[9], zero pad
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [LEVEL_W-1:0]    i_cfg_wdata
);

    t_top_state          r_state;
    t_top_state          n_state;

    logic                r_audio_ready;
    logic [LEVEL_W-1:0]  r_enter;
    logic [LEVEL_W-1:0]  r_exit;

    logic [LEVEL_W-1:0]  r_smooth;
    logic                r_primed;
    logic                r_flag;
    logic                r_muted_pend;

    logic                r_out_valid;
    logic [GAIN_W-1:0]   r_out_gain;
    logic                r_out_muted;

    logic                w_accept;
    logic                w_out_free;
    logic                w_load;
    logic [LEVEL_W-1:0]  w_raw;
    logic [13:0]         w_sum;
    logic [LEVEL_W-1:0]  n_smooth;
    logic                n_flag;
    logic                w_muted;
    logic                w_taper_done;
    logic [GAIN_W-1:0]   w_gain;

    assign w_raw      = C_LEVEL_MAX - i_s_axis_tdata[LEVEL_W-1:0];
    assign w_out_free = !r_out_valid || i_m_axis_tready;
    assign w_accept   = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        w_sum    = {r_smooth, 1'b0} + {2'b00, r_smooth} + {2'b00, w_raw} + 14'd2;
        n_smooth = r_primed ? w_sum[13:2] : w_raw;
        n_flag   = r_flag;
        if (!r_flag && (w_raw <= r_enter)) begin
            n_flag = 1'b1;
        end else if (r_flag && (w_raw >= r_exit)) begin
            n_flag = 1'b0;
        end
        w_muted  = r_audio_ready ? n_flag : 1'b1;
    end

    vktm_taper u_taper (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_level (n_smooth),
        .o_done  (w_taper_done),
        .o_gain  (w_gain)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (w_taper_done) begin
                    n_state = w_out_free ? ST_IDLE : ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_s_axis_tready = (r_state == ST_IDLE);
        w_load = ((r_state == ST_RUN) && w_taper_done && w_out_free)
              || ((r_state == ST_HOLD) && w_out_free);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_audio_ready <= 1'b0;
            r_enter       <= C_ENTER_RST;
            r_exit        <= C_EXIT_RST;
            r_smooth      <= '0;
            r_primed      <= 1'b0;
            r_flag        <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_AUDIO_READY: r_audio_ready <= i_cfg_wdata[0];
                    CFG_MUTE_ENTER:  r_enter       <= i_cfg_wdata;
                    CFG_MUTE_EXIT:   r_exit        <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if (w_accept) begin
                r_smooth <= n_smooth;
                r_primed <= 1'b1;
                if (r_audio_ready) begin
                    r_flag <= n_flag;
                end
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_muted_pend <= w_muted;
        end
        if (w_load) begin
            r_out_gain  <= w_gain;
            r_out_muted <= r_muted_pend;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_out_muted, r_out_gain};

endmodule

/* tb/volume_knob_taper_mute_unit_test.sv */
`timescale 1ns / 1ps
// self-checking bench for volume_knob_taper_mute_unit: a directed table, then random knob runs
// checked against an in-bench smoother, cubic taper and mute hysteresis model
// depends on vktm_pkg and the design sources
module volume_knob_taper_mute_unit_test;
    import vktm_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned DRAIN_CYCLES   = 80;
    localparam int unsigned RANDOM_ITEMS   = 1200;
    localparam int unsigned MAX_IDLE       = 17;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [GAIN_W-1:0] gain;
        logic              muted;
    } t_gain_mute;

    typedef struct {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] idx;
        logic [LEVEL_W-1:0]   value;
        bit                   known;
        t_gain_mute           result;
    } t_plan_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [15:0]          i_s_axis_tdata = '0;   // adc_code[11:0], zero pad
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b1;
    logic [15:0]          o_m_axis_tdata;        // gain[8:0], muted[9], zero pad
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [LEVEL_W-1:0]   i_cfg_wdata = '0;

    volume_knob_taper_mute_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    logic               model_ready = 1'b0;
    logic [LEVEL_W-1:0] model_enter = C_ENTER_RST;
    logic [LEVEL_W-1:0] model_exit  = C_EXIT_RST;
    logic [LEVEL_W-1:0] smooth_q    = '0;
    bit                 primed_q    = 1'b0;
    bit                 flag_q      = 1'b0;

    t_gain_mute expected_gain_mute[$];
    t_plan_row  plan[$];

    bit idle_on = 1'b1;
    int items_sent = 0;
    int cfg_writes = 0;
    int results_seen = 0;
    int mismatches = 0;
    int sink_hold = 0;
    int unsigned stuck_cycles = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [GAIN_W-1:0] taper_of(input logic [LEVEL_W-1:0] level);
        int unsigned lv;
        int unsigned v;
        int unsigned sq;
        int unsigned g;
        lv = level;
        if (lv <= C_TAPER_LOW) return '0;
        if (lv >= C_TAPER_HIGH) return C_GAIN_FULL[GAIN_W-1:0];
        v  = ((lv - C_TAPER_LOW) * C_TAPER_HIGH) / C_TAPER_SPAN;
        sq = (v * v) / C_TAPER_HIGH;
        v  = (sq * v) / C_TAPER_HIGH;
        g  = (v * C_GAIN_FULL + C_GAIN_ROUND) / C_TAPER_HIGH;
        return g[GAIN_W-1:0];
    endfunction

    function automatic t_gain_mute predict_gain_mute(input logic [LEVEL_W-1:0] code);
        logic [LEVEL_W-1:0] raw;
        int unsigned        acc;
        t_gain_mute         r;
        raw = C_LEVEL_MAX - code;
        if (!primed_q) begin
            smooth_q = raw;
            primed_q = 1'b1;
        end else begin
            acc = smooth_q * 3 + raw + 2;
            acc = acc >> 2;
            smooth_q = acc[LEVEL_W-1:0];
        end
        if (!model_ready) begin
            r.muted = 1'b1;
        end else begin
            if (!flag_q && raw <= model_enter)
                flag_q = 1'b1;
            else if (flag_q && raw >= model_exit)
                flag_q = 1'b0;
            r.muted = flag_q;
        end
        r.gain = taper_of(smooth_q);
        return r;
    endfunction

    function automatic logic [LEVEL_W-1:0] clamp_code(input int c);
        if (c < 0) return '0;
        if (c > 4095) return C_LEVEL_MAX;
        return c[LEVEL_W-1:0];
    endfunction

    function automatic t_plan_row reading(input logic [LEVEL_W-1:0] code);
        return '{is_cfg: 1'b0, idx: '0, value: code, known: 1'b0, result: '0};
    endfunction

    function automatic t_plan_row setting(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [LEVEL_W-1:0] value);
        return '{is_cfg: 1'b1, idx: idx, value: value, known: 1'b0, result: '0};
    endfunction

    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (expected_gain_mute.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LEVEL_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        case (idx)
            CFG_AUDIO_READY: model_ready = value[0];
            CFG_MUTE_ENTER:  model_enter = value;
            CFG_MUTE_EXIT:   model_exit  = value;
            default: ;
        endcase
        cfg_writes++;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_reading(input logic [LEVEL_W-1:0] code, input bit known,
                                input t_gain_mute typed);
        int         gap;
        t_gain_mute r;
        gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap != 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {4'b0000, code};
        do @(posedge i_clk); while (!o_s_axis_tready);
        r = predict_gain_mute(code);
        expected_gain_mute.push_back(known ? typed : r);
        items_sent++;
    endtask

    task automatic flag_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on result %0d: %s", results_seen, what);
    endtask

    always @(posedge i_clk) begin : sink
        t_gain_mute want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            results_seen++;
            if (expected_gain_mute.size() == 0) begin
                flag_mismatch($sformatf("unexpected result %h", o_m_axis_tdata));
            end else begin
                want = expected_gain_mute.pop_front();
                if (o_m_axis_tdata[GAIN_W-1:0] !== want.gain)
                    flag_mismatch($sformatf("gain expected %0d got %0d",
                                            want.gain, o_m_axis_tdata[GAIN_W-1:0]));
                if (o_m_axis_tdata[GAIN_W] !== want.muted)
                    flag_mismatch($sformatf("muted expected %0d got %0d",
                                            want.muted, o_m_axis_tdata[GAIN_W]));
            end
            sink_hold = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        end else if (sink_hold > 0) begin
            sink_hold--;
        end
        i_m_axis_tready <= (sink_hold == 0);
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready) ||
            i_cfg_we)
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no request moved for %0d cycles", stuck_cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        int                 first_random;
        int                 kind;
        int                 run;
        int                 base;
        int                 step;
        int                 pick;
        logic [LEVEL_W-1:0] e;
        logic [LEVEL_W-1:0] x;

        // first reading primes the smoother; audio not ready forces mute
        plan.push_back('{is_cfg: 1'b0, idx: '0, value: 12'd0, known: 1'b1,
                         result: '{gain: 9'd256, muted: 1'b1}});
        plan.push_back(reading(12'd4095));
        plan.push_back(reading(12'd4095));
        plan.push_back(setting(CFG_UNUSED, 12'hFFF));
        plan.push_back(setting(CFG_AUDIO_READY, 12'h001));
        // hysteresis around the reset thresholds
        plan.push_back(reading(12'd3445));
        plan.push_back(reading(12'd3246));
        plan.push_back(reading(12'd3245));
        plan.push_back(reading(12'd3444));
        // enter above exit: flag toggles every reading
        plan.push_back(setting(CFG_MUTE_ENTER, 12'd4095));
        plan.push_back(setting(CFG_MUTE_EXIT, 12'd0));
        plan.push_back(reading(12'd2000));
        plan.push_back(reading(12'd2000));
        plan.push_back(reading(12'd2000));
        plan.push_back(setting(CFG_MUTE_ENTER, 12'd0));
        plan.push_back(setting(CFG_MUTE_EXIT, 12'd4095));
        plan.push_back(reading(12'd4095));
        plan.push_back(reading(12'd1));
        plan.push_back(reading(12'd0));
        plan.push_back(reading(12'd4095));
        // audio drops out with the flag set: flag must hold
        plan.push_back(setting(CFG_AUDIO_READY, 12'hFFE));
        plan.push_back(reading(12'd0));
        plan.push_back(setting(CFG_AUDIO_READY, 12'h001));
        plan.push_back(reading(12'd4094));
        plan.push_back(setting(CFG_MUTE_ENTER, C_ENTER_RST));
        plan.push_back(setting(CFG_MUTE_EXIT, C_EXIT_RST));
        repeat (4) plan.push_back(reading(12'd0));
        repeat (4) plan.push_back(reading(12'd4095));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                wait_drained();
                write_reg(plan[i].idx, plan[i].value);
            end else begin
                send_reading(plan[i].value, plan[i].known, plan[i].result);
            end
        end

        first_random = items_sent;
        while (items_sent < first_random + int'(RANDOM_ITEMS)) begin
            wait_drained();
            write_reg(CFG_AUDIO_READY,
                      12'(($urandom_range(0, 4095) & 12'hFFE) | ($urandom_range(0, 3) != 0)));
            pick = $urandom_range(0, 4);
            case (pick)
                0: begin
                    e = 12'($urandom_range(0, 4095));
                    x = 12'($urandom_range(0, 4095));
                end
                1: begin
                    e = '0;
                    x = C_LEVEL_MAX;
                end
                2: begin
                    e = C_LEVEL_MAX;
                    x = '0;
                end
                3: begin
                    e = C_ENTER_RST;
                    x = C_EXIT_RST;
                end
                default: begin
                    e = 12'($urandom_range(0, 2000));
                    x = 12'(e + $urandom_range(0, 2095));
                end
            endcase
            write_reg(CFG_MUTE_ENTER, e);
            write_reg(CFG_MUTE_EXIT, x);
            idle_on = ($urandom_range(0, 3) != 0);

            repeat (8) begin
                kind = $urandom_range(0, 4);
                run  = $urandom_range(5, 40);
                base = $urandom_range(0, 4095);
                step = $urandom_range(1, 300) * ($urandom_range(0, 1) ? 1 : -1);
                if (kind == 3)
                    base = $urandom_range(0, 1) ? 4095 : 0;
                for (int k = 0; k < run && items_sent < first_random + int'(RANDOM_ITEMS);
                     k++) begin
                    case (kind)
                        0: send_reading(clamp_code(base + int'($urandom_range(0, 31)) - 16),
                                        1'b0, '0);
                        1: send_reading(clamp_code(base + k * step), 1'b0, '0);
                        2: send_reading(12'($urandom_range(0, 4095)), 1'b0, '0);
                        3: send_reading(base[LEVEL_W-1:0], 1'b0, '0);
                        // raw levels at or within 2 of the mute thresholds
                        default: send_reading(clamp_code(4095 -
                                     int'($urandom_range(0, 1) ? model_enter : model_exit) +
                                     int'($urandom_range(0, 4)) - 2), 1'b0, '0);
                    endcase
                end
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d knob readings over %0d register writes", items_sent, cfg_writes);
        $display("compared %0d results, %0d mismatches", results_seen, mismatches);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

/* files.f */
design/vktm_pkg.sv
design/vktm_div.sv
design/vktm_taper.sv
design/volume_knob_taper_mute_unit.sv
tb/volume_knob_taper_mute_unit_test.sv
